// ===== rtl/core/awwrc_pkg.sv =====
// ----------------------------------------------------------------------------
// awwrc_pkg
// Shared widths, constants and types of the adaptive write window controller.
// ----------------------------------------------------------------------------
package awwrc_pkg;

   // Counter and time widths
   localparam int COUNT_WIDTH = 32;
   localparam int TIME_WIDTH  = 48;

   // Field widths
   localparam int BB_W     = 25;
   localparam int TGT_W    = 40;
   localparam int KIB_W    = 32;
   localparam int BLK_W    = 21;
   localparam int ELA_W    = 48;
   localparam int HINT_W   = 56;
   localparam int SUMB_W   = 48;
   localparam int SUMT_W   = 56;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 40;

   // Datapath widths
   localparam int MUL_W   = 32;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int NS_W    = 30;
   localparam int HB_W    = COUNT_WIDTH + BB_W;
   localparam int DVD_W   = HB_W + NS_W + 1;
   localparam int DLY_W   = TIME_WIDTH + 2;
   localparam int DVS_W   = DLY_W;
   localparam int KIB_SH  = 10;
   localparam int RATE_W  = KIB_W + KIB_SH;
   localparam int DR_W    = DLY_W + RATE_W;
   localparam int CNT_DIV_W = $clog2(DVD_W);

   // Stream word widths
   localparam int REQ_W = ((BLK_W + ELA_W + 7) / 8) * 8;
   localparam int RSP_BITS = 1 + 2 + COUNT_WIDTH + 1 + HINT_W + TIME_WIDTH + HINT_W
                             + SUMB_W + SUMT_W;
   localparam int RSP_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [NS_W-1:0]        NS_PER_S   = NS_W'(1000000000);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = {COUNT_WIDTH{1'b1}};
   localparam logic [TIME_WIDTH-1:0]  TIME_MAX   = {TIME_WIDTH{1'b1}};
   localparam logic [HINT_W-1:0]      HINT_MAX   = {HINT_W{1'b1}};
   localparam logic [SUMB_W-1:0]      SUMB_MAX   = {SUMB_W{1'b1}};
   localparam logic [SUMT_W-1:0]      SUMT_MAX   = {SUMT_W{1'b1}};

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_BYTES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_NS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_RATE    = 2'd2;

   typedef enum logic [1:0] {
      MODE_INC    = 2'd0,
      MODE_DEC    = 2'd1,
      MODE_SEARCH = 2'd2,
      MODE_STEADY = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_HB, ST_BG0, ST_BG1, ST_SPD_GO, ST_SPD_W, ST_HINT,
      ST_DRI, ST_DR0, ST_DR1, ST_THR, ST_WAIT_W, ST_CTL, ST_REMI, ST_REMC
   } state_type;

endpackage

// ===== rtl/core/adaptive_write_window_rate_controller.sv =====
// ----------------------------------------------------------------------------
// adaptive_write_window_rate_controller
// Sizes the measurement window in blocks, computes speed and throttle wait on
// window close and steps the increase/decrease/search/steady mode machine.
// A closing item runs one serial divide for its speed, and one with a throttle
// wait runs three serial divides. The next word is accepted in the cycle
// after the response word is loaded, so the block takes one item at a time; a
// stalled response word holds the block. The serial divider and the shared
// 32x32 multiplier are used in turn by the steps of the sequencer.
// Reset (synchronous) restores the register defaults and the control state.
// ----------------------------------------------------------------------------
module adaptive_write_window_rate_controller
   import awwrc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request words
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [REQ_W-1:0]     req_tdata,  // blocks_done[20:0], elapsed_ns[68:21]
   input  logic                 req_tuser,  // req_type
   // response words
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata,  // window_closed, mode, blocks_per_window,
                                            // chunk_hint_valid, chunk_hint_bytes,
                                            // wait_ns, speed_bps, blocks_total,
                                            // time_total_ns, zero pad
   // register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   localparam int CW = COUNT_WIDTH;
   localparam int TW = TIME_WIDTH;

   state_type state_ff, state_in;

   logic [BB_W-1:0]   bb_ff;
   logic [TGT_W-1:0]  tgt_ff;
   logic [KIB_W-1:0]  kib_ff;

   logic              typ_ff;
   logic [BLK_W-1:0]  blk_ff;
   logic [ELA_W-1:0]  ela_ff;

   mode_type          mode_ff, mode_in;
   logic [CW-1:0]     wt_ff, wt_in;
   logic [CW-1:0]     step_ff, step_in;
   logic [CW-1:0]     slo_ff, slo_in;
   logic [CW-1:0]     shi_ff, shi_in;
   logic              fix_ff, fix_in;
   logic [CW-1:0]     wb_ff;
   logic [TW-1:0]     paused_ff;
   logic [HINT_W-1:0] hbytes_ff;
   logic [HINT_W-1:0] hspeed_ff;
   logic [SUMB_W-1:0] sumb_ff;
   logic [SUMT_W-1:0] sumt_ff;

   logic              closed_ff;
   logic              pass2_ff;
   logic [TW-1:0]     wait_ff;
   logic [HINT_W-1:0] speed_ff;
   logic [DLY_W-1:0]  delay_ff;
   logic [HB_W-1:0]   hb_ff;
   logic [PROD_W-1:0] acc_ff;
   logic [DVD_W-1:0]  bg_ff;
   logic [DR_W-1:0]   dr_ff;

   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff;

   logic [MUL_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] prod;
   logic              div_start, div_done;
   logic [DVD_W-1:0]  div_dividend, div_quot;
   logic [DVS_W-1:0]  div_divisor;

   logic [CW:0]       wb_sum;
   logic [CW-1:0]     wb_new;
   logic [TW:0]       paused_sum;
   logic [DLY_W-1:0]  delay_load;
   logic [DVD_W-1:0]  bg_sum;
   logic [DR_W-1:0]   dr_sum;
   logic              limited;
   logic [RATE_W-1:0] rate;
   logic [DR_W-1:0]   bg_ext;
   logic              cap_gt, cap_lt;
   logic              thr_go;
   logic [DVD_W-1:0]  num;
   logic [HINT_W-1:0] q_spd;
   logic [TW-1:0]     q_wait;
   logic [DLY_W-1:0]  wsum;
   logic [TW-1:0]     w_fin;
   logic              dly_gt_tgt;
   logic              above_cap, below_cap, above, below;
   logic [SUMB_W:0]   sumb_sum;
   logic [SUMT_W:0]   sumt_sum;
   logic [CW-1:0]     left;
   logic [HINT_W-1:0] rem_sat, rem_fin;
   logic [HINT_W-1:0] hb_sat;
   logic              hint_take;
   logic              rsp_load;

   // shared units
   awwrc_mul u_mul (
      .clock    (clock),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_prod (prod)
   );

   awwrc_div u_div (
      .clock        (clock),
      .reset        (reset),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_done     (div_done),
      .div_quot     (div_quot)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bb_ff  <= BB_W'(4096);
         tgt_ff <= TGT_W'(1000000000);
         kib_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_BLOCK_BYTES: bb_ff  <= csr_data[BB_W-1:0];
            REG_TARGET_NS:   tgt_ff <= csr_data[TGT_W-1:0];
            REG_MAX_RATE:    kib_ff <= csr_data[KIB_W-1:0];
            default: ;
         endcase
      end
   end

   // item bookkeeping
   assign wb_sum     = {1'b0, wb_ff} + (CW+1)'(blk_ff);
   assign wb_new     = wb_sum[CW] ? COUNT_MAX : wb_sum[CW-1:0];
   assign paused_sum = {1'b0, paused_ff} + (TW+1)'(ela_ff);
   assign delay_load = DLY_W'(ela_ff) + DLY_W'(paused_ff);

   // product accumulation
   assign bg_sum = DVD_W'(acc_ff) + (DVD_W'(prod) << MUL_W);
   assign dr_sum = DR_W'(acc_ff) + (DR_W'(prod) << MUL_W);

   // rate cap compares
   assign limited = (kib_ff != '0);
   assign rate    = {kib_ff, {KIB_SH{1'b0}}};
   assign bg_ext  = DR_W'(bg_ff);
   assign cap_gt  = bg_ext > dr_ff;
   assign cap_lt  = bg_ext < dr_ff;
   assign thr_go  = limited && (delay_ff < DLY_W'(tgt_ff)) && cap_gt;
   assign num     = DVD_W'(bg_ext - dr_ff + DR_W'(rate >> 1));

   assign dly_gt_tgt = delay_ff > DLY_W'(tgt_ff);
   assign above_cap  = limited && cap_gt;
   assign below_cap  = !limited || cap_lt;
   assign above      = dly_gt_tgt || above_cap;
   assign below      = !dly_gt_tgt && below_cap;

   // divider operands and saturated quotients
   assign div_start = ((state_ff == ST_SPD_GO) && (delay_ff != '0)) ||
                      ((state_ff == ST_THR) && thr_go);
   assign div_dividend = (state_ff == ST_THR) ? num : bg_ff;
   assign div_divisor  = (state_ff == ST_THR) ? DVS_W'(rate) : delay_ff;
   assign q_spd  = (|div_quot[DVD_W-1:HINT_W]) ? HINT_MAX : div_quot[HINT_W-1:0];
   assign q_wait = (|div_quot[DVD_W-1:TW]) ? TIME_MAX : div_quot[TW-1:0];
   assign wsum   = delay_ff + DLY_W'(q_wait);
   assign w_fin  = (wsum < DLY_W'(tgt_ff)) ? TW'(DLY_W'(tgt_ff) - delay_ff) : q_wait;

   // running sums
   assign sumb_sum = {1'b0, sumb_ff} + (SUMB_W+1)'(wb_ff);
   assign sumt_sum = {1'b0, sumt_ff} + (SUMT_W+1)'(delay_ff);

   // hint capture
   assign hb_sat    = (|hb_ff[HB_W-1:HINT_W]) ? HINT_MAX : hb_ff[HINT_W-1:0];
   assign hint_take = !fix_ff && !((hbytes_ff != '0) && (speed_ff < hspeed_ff));

   // bytes left in the window
   assign left    = (wt_ff > wb_ff) ? (wt_ff - wb_ff) : '0;
   assign rem_sat = (|prod[PROD_W-1:HINT_W]) ? HINT_MAX : prod[HINT_W-1:0];
   assign rem_fin = (fix_ff && (rem_sat >= hbytes_ff)) ? hbytes_ff : rem_sat;
   assign rsp_load = (state_ff == ST_REMC) && (!rsp_valid_ff || rsp_tready);

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_LOAD: begin
            mul_a = wt_ff;
            mul_b = MUL_W'(bb_ff);
         end
         ST_HB: begin
            mul_a = prod[MUL_W-1:0];
            mul_b = MUL_W'(NS_PER_S);
         end
         ST_BG0: begin
            mul_a = MUL_W'(hb_ff[HB_W-1:MUL_W]);
            mul_b = MUL_W'(NS_PER_S);
         end
         ST_DRI: begin
            mul_a = delay_ff[MUL_W-1:0];
            mul_b = kib_ff;
         end
         ST_DR0: begin
            mul_a = MUL_W'(delay_ff[DLY_W-1:MUL_W]);
            mul_b = kib_ff;
         end
         ST_REMI, ST_REMC: begin
            mul_a = left;
            mul_b = MUL_W'(bb_ff);
         end
         default: ;
      endcase
   end

   // mode machine step on window close
   always_comb begin
      logic [CW-1:0] half_step;
      logic [CW-1:0] adj_step;
      logic          do_grow;
      logic          do_shrink;
      logic          gs_go;
      logic [CW:0]   gs_lo;
      logic [CW:0]   gs_hi;
      logic [CW:0]   sum_v;
      logic [CW:0]   lo2;
      logic [CW:0]   hi2;
      logic [CW-1:0] lo3;
      logic [CW-1:0] hi3;

      mode_in   = mode_ff;
      wt_in     = wt_ff;
      step_in   = step_ff;
      slo_in    = slo_ff;
      shi_in    = shi_ff;
      fix_in    = fix_ff;
      half_step = step_ff >> 1;
      adj_step  = step_ff;
      do_grow   = 1'b0;
      do_shrink = 1'b0;
      gs_go     = 1'b0;
      gs_lo     = '0;
      gs_hi     = '0;
      sum_v     = '0;
      lo2       = '0;
      hi2       = '0;
      lo3       = '0;
      hi3       = '0;

      case (mode_ff)
         MODE_INC: begin
            if (above) begin
               fix_in = 1'b1;
               gs_go  = 1'b1;
               gs_lo  = (wt_ff > half_step) ? (CW+1)'(wt_ff - half_step) : (CW+1)'(1);
               gs_hi  = {1'b0, wt_ff};
            end else if (below) begin
               do_grow = 1'b1;
            end else begin
               mode_in = MODE_STEADY;
            end
         end
         MODE_DEC: begin
            if (above) begin
               do_shrink = 1'b1;
            end else if (below) begin
               gs_go = 1'b1;
               gs_lo = {1'b0, wt_ff};
               gs_hi = {1'b0, wt_ff} + {1'b0, half_step};
            end else begin
               mode_in = MODE_STEADY;
            end
         end
         MODE_SEARCH: begin
            if ({1'b0, shi_ff} <= ({1'b0, slo_ff} + (CW+1)'(3))) begin
               mode_in = MODE_STEADY;
            end else if (above) begin
               shi_in = wt_ff;
               sum_v  = {1'b0, slo_ff} + {1'b0, wt_ff};
               wt_in  = sum_v[CW:1];
            end else if (below) begin
               slo_in = wt_ff;
               sum_v  = {1'b0, wt_ff} + {1'b0, shi_ff};
               wt_in  = sum_v[CW:1];
            end else begin
               mode_in = MODE_STEADY;
            end
         end
         MODE_STEADY: begin
            // restart the step at one before growing or shrinking
            if (!fix_ff) begin
               fix_in = 1'b1;
            end else if (!dly_gt_tgt) begin
               if (below_cap) begin
                  adj_step = CW'(1);
                  step_in  = CW'(1);
                  mode_in  = MODE_INC;
                  do_grow  = 1'b1;
               end else if (above_cap) begin
                  adj_step  = CW'(1);
                  step_in   = CW'(1);
                  mode_in   = MODE_DEC;
                  do_shrink = 1'b1;
               end
            end else if (wt_ff > CW'(1)) begin
               adj_step  = CW'(1);
               step_in   = CW'(1);
               mode_in   = MODE_DEC;
               do_shrink = 1'b1;
            end
         end
         default: ;
      endcase

      // grow: add the step, double it
      if (do_grow) begin
         sum_v   = {1'b0, wt_ff} + {1'b0, adj_step};
         wt_in   = sum_v[CW] ? COUNT_MAX : sum_v[CW-1:0];
         sum_v   = {1'b0, adj_step} + {1'b0, adj_step};
         step_in = sum_v[CW] ? COUNT_MAX : sum_v[CW-1:0];
      end

      // shrink: subtract the step or fall back to a search
      if (do_shrink) begin
         if (wt_ff > adj_step) begin
            wt_in   = wt_ff - adj_step;
            sum_v   = {1'b0, adj_step} + {1'b0, adj_step};
            step_in = sum_v[CW] ? COUNT_MAX : sum_v[CW-1:0];
         end else begin
            gs_go = 1'b1;
            gs_lo = (CW+1)'(1);
            gs_hi = {1'b0, wt_ff} + {1'b0, adj_step >> 1};
         end
      end

      // enter a binary search between clamped bounds, or go steady if they lie within three
      if (gs_go) begin
         lo2   = (gs_lo == '0) ? (CW+1)'(1) : gs_lo;
         hi2   = (gs_hi < lo2) ? lo2 : gs_hi;
         lo3   = lo2[CW] ? COUNT_MAX : lo2[CW-1:0];
         hi3   = hi2[CW] ? COUNT_MAX : hi2[CW-1:0];
         sum_v = {1'b0, lo3} + {1'b0, hi3};
         wt_in = sum_v[CW:1];
         if ((hi3 - lo3) <= CW'(3)) begin
            mode_in = MODE_STEADY;
         end else begin
            slo_in  = lo3;
            shi_in  = hi3;
            mode_in = MODE_SEARCH;
         end
      end

      if (wt_in == '0) begin
         wt_in = CW'(1);
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_LOAD;
         ST_LOAD: begin
            if (!typ_ff && (wb_new >= wt_ff)) state_in = ST_HB;
            else state_in = ST_REMI;
         end
         ST_HB:     state_in = ST_BG0;
         ST_BG0:    state_in = ST_BG1;
         ST_BG1:    state_in = ST_SPD_GO;
         ST_SPD_GO: begin
            if (delay_ff != '0) state_in = ST_SPD_W;
            else state_in = ST_HINT;
         end
         ST_SPD_W: begin
            if (div_done) state_in = pass2_ff ? ST_DRI : ST_HINT;
         end
         ST_HINT:   state_in = ST_DRI;
         ST_DRI:    state_in = ST_DR0;
         ST_DR0:    state_in = ST_DR1;
         ST_DR1:    state_in = pass2_ff ? ST_CTL : ST_THR;
         ST_THR:    state_in = thr_go ? ST_WAIT_W : ST_CTL;
         ST_WAIT_W: begin
            if (div_done) state_in = (w_fin != '0) ? ST_SPD_GO : ST_CTL;
         end
         ST_CTL:    state_in = ST_REMI;
         ST_REMI:   state_in = ST_REMC;
         ST_REMC:   if (rsp_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_INC;
         wt_ff     <= CW'(1);
         step_ff   <= CW'(1);
         slo_ff    <= '0;
         shi_ff    <= '0;
         wb_ff     <= '0;
         paused_ff <= '0;
         fix_ff    <= 1'b0;
         hbytes_ff <= '0;
         hspeed_ff <= '0;
         sumb_ff   <= '0;
         sumt_ff   <= '0;
         pass2_ff  <= 1'b0;
      end else begin
         case (state_ff)
            ST_LOAD: begin
               pass2_ff <= 1'b0;
               if (typ_ff) begin
                  if (wb_ff != '0) begin
                     paused_ff <= paused_sum[TW] ? TIME_MAX : paused_sum[TW-1:0];
                  end
               end else begin
                  wb_ff <= wb_new;
               end
            end
            ST_HINT: begin
               if (hint_take) begin
                  hbytes_ff <= hb_sat;
                  hspeed_ff <= speed_ff;
               end
            end
            ST_WAIT_W: begin
               if (div_done && (w_fin != '0)) pass2_ff <= 1'b1;
            end
            ST_CTL: begin
               mode_ff   <= mode_in;
               wt_ff     <= wt_in;
               step_ff   <= step_in;
               slo_ff    <= slo_in;
               shi_ff    <= shi_in;
               fix_ff    <= fix_in;
               sumb_ff   <= sumb_sum[SUMB_W] ? SUMB_MAX : sumb_sum[SUMB_W-1:0];
               sumt_ff   <= sumt_sum[SUMT_W] ? SUMT_MAX : sumt_sum[SUMT_W-1:0];
               wb_ff     <= '0;
               paused_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   // item and window payload
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            typ_ff <= req_tuser;
            blk_ff <= req_tdata[BLK_W-1:0];
            ela_ff <= req_tdata[BLK_W+ELA_W-1:BLK_W];
         end
         ST_LOAD: begin
            closed_ff <= !typ_ff && (wb_new >= wt_ff);
            wait_ff   <= '0;
            speed_ff  <= '0;
            delay_ff  <= delay_load;
         end
         ST_HB:  hb_ff  <= prod[HB_W-1:0];
         ST_BG0: acc_ff <= prod;
         ST_BG1: bg_ff  <= bg_sum;
         ST_SPD_GO: begin
            if (delay_ff == '0) speed_ff <= HINT_MAX;
         end
         ST_SPD_W: begin
            if (div_done) speed_ff <= q_spd;
         end
         ST_DR0: acc_ff <= prod;
         ST_DR1: dr_ff  <= dr_sum << KIB_SH;
         ST_WAIT_W: begin
            if (div_done) begin
               wait_ff  <= w_fin;
               delay_ff <= delay_ff + DLY_W'(w_fin);
            end
         end
         default: ;
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= RSP_W'({sumt_ff, sumb_ff, speed_ff, wait_ff, rem_fin, fix_ff,
                                wt_ff, mode_ff, closed_ff});
      end
   end

   // checks
   a_target_nonzero: assert property (@(posedge clock) disable iff (reset)
      wt_ff != '0)
      else $error("window target reached zero");

   a_window_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CTL) |=> (wb_ff == '0) && (paused_ff == '0))
      else $error("window not cleared after close");

   a_hint_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(fix_ff))
      else $error("chunk hint lost its fixed flag");

   a_search_order: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_SEARCH) |-> (shi_ff > slo_ff))
      else $error("search bounds out of order");

endmodule

// ===== rtl/core/awwrc_mul.sv =====
// ----------------------------------------------------------------------------
// awwrc_mul
// Shared 32 x 32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module awwrc_mul
   import awwrc_pkg::*;
(
   input  logic              clock,
   input  logic [MUL_W-1:0]  mul_a,
   input  logic [MUL_W-1:0]  mul_b,
   output logic [PROD_W-1:0] mul_prod
);

   logic [PROD_W-1:0] prod_ff;

   // register the product every cycle
   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   assign mul_prod = prod_ff;

endmodule

// ===== rtl/core/awwrc_div.sv =====
// ----------------------------------------------------------------------------
// awwrc_div
// Restoring bit-serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module awwrc_div
   import awwrc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             div_start,
   input  logic [DVD_W-1:0] div_dividend,
   input  logic [DVS_W-1:0] div_divisor,
   output logic             div_done,
   output logic [DVD_W-1:0] div_quot
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_DIV_W-1:0] cnt_ff;
   logic [DVD_W-1:0]     quo_ff;
   logic [DVS_W-1:0]     rem_ff;
   logic [DVS_W-1:0]     dvs_ff;
   logic [DVS_W:0]       rem_sh;
   logic [DVS_W:0]       rem_diff;
   logic                 take;

   // shift in the next dividend bit and try the subtract
   assign rem_sh   = {rem_ff, quo_ff[DVD_W-1]};
   assign rem_diff = rem_sh - {1'b0, dvs_ff};
   assign take     = rem_sh >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_DIV_W'(DVD_W - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   // quotient bits replace dividend bits from the bottom
   always_ff @(posedge clock) begin
      if (div_start) begin
         quo_ff <= div_dividend;
         rem_ff <= '0;
         dvs_ff <= div_divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DVD_W-2:0], take};
         rem_ff <= take ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      end
   end

   assign div_done = done_ff;
   assign div_quot = quo_ff;

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the adaptive write window rate controller. A table
// of directed words runs first, then constrained-random phases under several
// register settings. Every response word is checked against an in-bench
// window/rate predictor.
// ----------------------------------------------------------------------------
module tb;
   import awwrc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          WATCHDOG_LIMIT = 20000;
   localparam int          HOLD_CYCLES    = 3000;
   localparam int          DRAIN_CYCLES   = 400;
   localparam int          RAND_PER_PHASE = 233;
   localparam int          NUM_PHASES     = 7;
   localparam bit [63:0]   BLK_FMAX       = (64'd1 << BLK_W) - 1;
   localparam bit [63:0]   ELA_FMAX       = (64'd1 << ELA_W) - 1;
   localparam bit [63:0]   C_MAX          = 64'(COUNT_MAX);
   localparam bit [63:0]   T_MAX          = 64'(TIME_MAX);
   localparam bit [63:0]   H_MAX          = 64'(HINT_MAX);
   localparam bit [63:0]   SB_MAX         = 64'(SUMB_MAX);
   localparam bit [63:0]   ST_MAX         = 64'(SUMT_MAX);
   localparam bit [63:0]   NS_SEC         = 64'd1000000000;

   typedef struct packed {
      bit        closed;
      mode_type  mode;
      bit [31:0] bpw;
      bit        hint_ok;
      bit [55:0] hint;
      bit [47:0] wait_ns;
      bit [55:0] speed;
      bit [47:0] tot_blk;
      bit [55:0] tot_time;
   } window_rsp_type;

   typedef struct {
      bit        is_pause;
      bit [63:0] blocks;
      bit [63:0] elapsed;
      bit        typed;
      bit        exp_closed;
      bit [31:0] exp_bpw;    // 0: predictor value kept
   } dir_row_type;

   typedef struct {
      bit [63:0] bb;
      bit [63:0] tgt;
      bit [63:0] kib;
      bit        long_hold;
   } setting_type;

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata;
   logic               req_tuser;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               csr_valid;
   logic               csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_data;

   // predictor copy of registers and control state
   bit [63:0] p_bb, p_tgt, p_kib;
   bit [1:0]  p_mode;
   bit [63:0] p_win_tgt, p_step, p_lo, p_hi, p_win_blk, p_paused;
   bit        p_hint_ok;
   bit [63:0] p_hint_b, p_hint_spd, p_tot_blk, p_tot_time;

   window_rsp_type expected_rsp_q[$];
   int             errors;
   bit             hold_req;
   int             idle_cycles;

   adaptive_write_window_rate_controller uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic bit [63:0] sat_add(bit [63:0] a, bit [63:0] b, bit [63:0] mx);
      bit [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, mx}) ? mx : s[63:0];
   endfunction

   function automatic bit [63:0] div_sat(bit [127:0] a, bit [63:0] d, bit [63:0] mx);
      bit [127:0] q;
      q = a / {64'd0, d};
      return (q > {64'd0, mx}) ? mx : q[63:0];
   endfunction

   function automatic void enter_search(bit [63:0] lo, bit [63:0] hi);
      if (lo < 1) lo = 1;
      if (hi < lo) hi = lo;
      if (lo > C_MAX) lo = C_MAX;
      if (hi > C_MAX) hi = C_MAX;
      p_win_tgt = (lo + hi) / 2;
      if (hi - lo <= 3) begin
         p_mode = MODE_STEADY;
      end else begin
         p_lo   = lo;
         p_hi   = hi;
         p_mode = MODE_SEARCH;
      end
   endfunction

   function automatic void grow_window();
      p_win_tgt = sat_add(p_win_tgt, p_step, C_MAX);
      p_step    = sat_add(p_step, p_step, C_MAX);
   endfunction

   function automatic void shrink_window();
      if (p_win_tgt > p_step) begin
         p_win_tgt = p_win_tgt - p_step;
         p_step    = sat_add(p_step, p_step, C_MAX);
      end else begin
         enter_search(1, p_win_tgt + p_step / 2);
      end
   endfunction

   function automatic window_rsp_type predict_window(bit is_pause, bit [63:0] blocks,
                                                     bit [63:0] elapsed);
      window_rsp_type r;
      bit [63:0]   wt, speed, rate, delay, left, rem;
      bit [127:0]  bytes_g, dr, hb, rb;
      bit          limited, above_cap, below_cap, above, below;
      r     = '0;
      wt    = 0;
      speed = 0;
      if (is_pause) begin
         if (p_win_blk > 0) p_paused = sat_add(p_paused, elapsed, T_MAX);
      end else begin
         p_win_blk = sat_add(p_win_blk, blocks, C_MAX);
         if (p_win_blk >= p_win_tgt) begin
            rate    = p_kib * 1024;
            limited = rate != 0;
            delay   = elapsed + p_paused;
            hb      = 128'(p_win_tgt) * 128'(p_bb);
            bytes_g = hb * 128'(NS_SEC);
            r.closed = 1;
            speed = (delay != 0) ? div_sat(bytes_g, delay, H_MAX) : H_MAX;
            if (!p_hint_ok && !(p_hint_b != 0 && speed < p_hint_spd)) begin
               p_hint_b   = (hb > 128'(H_MAX)) ? H_MAX : hb[63:0];
               p_hint_spd = speed;
            end
            // throttle when the window is short and over the cap
            dr = 128'(delay) * 128'(rate);
            if (limited && delay < p_tgt && bytes_g > dr) begin
               wt = div_sat(bytes_g - dr + 128'(rate / 2), rate, T_MAX);
               if (delay + wt < p_tgt) wt = p_tgt - delay;
               if (wt > 0) begin
                  delay = delay + wt;
                  speed = div_sat(bytes_g, delay, H_MAX);
               end
            end
            p_tot_blk  = sat_add(p_tot_blk, p_win_blk, SB_MAX);
            p_tot_time = sat_add(p_tot_time, delay, ST_MAX);
            dr        = 128'(delay) * 128'(rate);
            above_cap = limited && bytes_g > dr;
            below_cap = !limited || bytes_g < dr;
            above     = delay > p_tgt || above_cap;
            below     = delay <= p_tgt && below_cap;
            // step the mode machine
            case (p_mode)
               MODE_INC: begin
                  if (above) begin
                     p_hint_ok = 1;
                     enter_search(p_win_tgt > p_step / 2 ? p_win_tgt - p_step / 2 : 1,
                                  p_win_tgt);
                  end else if (below) begin
                     grow_window();
                  end else begin
                     p_mode = MODE_STEADY;
                  end
               end
               MODE_DEC: begin
                  if (above) shrink_window();
                  else if (below) enter_search(p_win_tgt, p_win_tgt + p_step / 2);
                  else p_mode = MODE_STEADY;
               end
               MODE_SEARCH: begin
                  if (p_hi <= p_lo + 3) begin
                     p_mode = MODE_STEADY;
                  end else if (above) begin
                     p_hi      = p_win_tgt;
                     p_win_tgt = (p_lo + p_hi) / 2;
                  end else if (below) begin
                     p_lo      = p_win_tgt;
                     p_win_tgt = (p_lo + p_hi) / 2;
                  end else begin
                     p_mode = MODE_STEADY;
                  end
               end
               default: begin
                  if (!p_hint_ok) begin
                     p_hint_ok = 1;
                  end else if (delay <= p_tgt) begin
                     if (below_cap) begin
                        p_step = 1; p_mode = MODE_INC; grow_window();
                     end else if (above_cap) begin
                        p_step = 1; p_mode = MODE_DEC; shrink_window();
                     end
                  end else if (p_win_tgt > 1) begin
                     p_step = 1; p_mode = MODE_DEC; shrink_window();
                  end
               end
            endcase
            if (p_win_tgt < 1) p_win_tgt = 1;
            p_win_blk = 0;
            p_paused  = 0;
         end
      end
      left = (p_win_tgt > p_win_blk) ? p_win_tgt - p_win_blk : 0;
      rb   = 128'(left) * 128'(p_bb);
      rem  = (rb > 128'(H_MAX)) ? H_MAX : rb[63:0];
      if (p_hint_ok && rem >= p_hint_b) rem = p_hint_b;
      r.mode     = mode_type'(p_mode);
      r.bpw      = p_win_tgt[31:0];
      r.hint_ok  = p_hint_ok;
      r.hint     = rem[55:0];
      r.wait_ns  = wt[47:0];
      r.speed    = speed[55:0];
      r.tot_blk  = p_tot_blk[47:0];
      r.tot_time = p_tot_time[55:0];
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   task automatic send_word(bit is_pause, bit [63:0] blocks, bit [63:0] elapsed,
                            bit typed, bit exp_closed, bit [31:0] exp_bpw);
      window_rsp_type r;
      req_tvalid = 1;
      req_tuser  = is_pause;
      req_tdata  = '0;
      req_tdata[BLK_W-1:0]           = blocks[BLK_W-1:0];
      req_tdata[BLK_W+ELA_W-1:BLK_W] = elapsed[ELA_W-1:0];
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      r = predict_window(is_pause, blocks & BLK_FMAX, elapsed & ELA_FMAX);
      if (typed) begin
         r.closed = exp_closed;
         if (exp_bpw != 0) r.bpw = exp_bpw;
      end
      expected_rsp_q.push_back(r);
      @(negedge clock);
      req_tvalid = 0;
   endtask

   task automatic write_reg(bit [CSR_IDX_W-1:0] idx, bit [63:0] value);
      csr_valid = 1;
      csr_index = idx;
      csr_data  = value[CSR_DAT_W-1:0];
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      case (idx)
         REG_BLOCK_BYTES: p_bb  = value & ((64'd1 << BB_W) - 1);
         REG_TARGET_NS:   p_tgt = value & ((64'd1 << TGT_W) - 1);
         REG_MAX_RATE:    p_kib = value & ((64'd1 << KIB_W) - 1);
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 0;
   endtask

   // hold the sender until every response is back, then let the block settle
   task automatic drain();
      while (expected_rsp_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic bit [63:0] pick_elapsed(bit pause);
      bit [63:0] e;
      case ($urandom_range(0, 9))
         0:       e = {$urandom, $urandom} & ELA_FMAX;
         1:       e = $urandom_range(0, 1000);
         2:       e = p_tgt;
         default: e = pause ? (p_tgt * $urandom_range(0, 50)) / 200
                            : (p_tgt * $urandom_range(1, 399)) / 200 + $urandom_range(0, 3);
      endcase
      return e & ELA_FMAX;
   endfunction

   function automatic bit [63:0] pick_blocks(bit closing);
      bit [63:0] need;
      need = (p_win_tgt > p_win_blk) ? p_win_tgt - p_win_blk : 0;
      if ($urandom_range(0, 19) == 0) return $urandom & BLK_FMAX;
      if (closing) need = need + ($urandom_range(0, 3) == 0 ? $urandom_range(0, 5) : 0);
      else need = $urandom_range(0, 32'(need / 2 > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : need / 2));
      return (need > BLK_FMAX) ? BLK_FMAX : need;
   endfunction

   // ------------------------------------------------------------------------
   // response checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      window_rsp_type exp_r;
      window_rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.closed   = rsp_tdata[0];
         got.mode     = mode_type'(rsp_tdata[2:1]);
         got.bpw      = rsp_tdata[34:3];
         got.hint_ok  = rsp_tdata[35];
         got.hint     = rsp_tdata[91:36];
         got.wait_ns  = rsp_tdata[139:92];
         got.speed    = rsp_tdata[195:140];
         got.tot_blk  = rsp_tdata[243:196];
         got.tot_time = rsp_tdata[299:244];
         if (expected_rsp_q.size() == 0) begin
            $error("response word with nothing expected");
            errors++;
         end else begin
            exp_r = expected_rsp_q.pop_front();
            if (got.closed !== exp_r.closed) begin
               $error("window_closed exp %0d got %0d", exp_r.closed, got.closed);
               errors++;
            end
            if (got.mode !== exp_r.mode) begin
               $error("mode exp %0d got %0d", exp_r.mode, got.mode);
               errors++;
            end
            if (got.bpw !== exp_r.bpw) begin
               $error("blocks_per_window exp %0d got %0d", exp_r.bpw, got.bpw);
               errors++;
            end
            if (got.hint_ok !== exp_r.hint_ok) begin
               $error("chunk_hint_valid exp %0d got %0d", exp_r.hint_ok, got.hint_ok);
               errors++;
            end
            if (got.hint !== exp_r.hint) begin
               $error("chunk_hint_bytes exp %0d got %0d", exp_r.hint, got.hint);
               errors++;
            end
            if (got.wait_ns !== exp_r.wait_ns) begin
               $error("wait_ns exp %0d got %0d", exp_r.wait_ns, got.wait_ns);
               errors++;
            end
            if (got.speed !== exp_r.speed) begin
               $error("speed_bps exp %0d got %0d", exp_r.speed, got.speed);
               errors++;
            end
            if (got.tot_blk !== exp_r.tot_blk) begin
               $error("blocks_total exp %0d got %0d", exp_r.tot_blk, got.tot_blk);
               errors++;
            end
            if (got.tot_time !== exp_r.tot_time) begin
               $error("time_total_ns exp %0d got %0d", exp_r.tot_time, got.tot_time);
               errors++;
            end
         end
      end
   end

   // receiver stall pattern, with one long hold-off on request
   always @(negedge clock) begin
      int hold_left;
      bit [15:0] pat;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready = 0;
      end else if (hold_req) begin
         hold_req   = 0;
         hold_left  = HOLD_CYCLES;
         rsp_tready = 0;
      end else begin
         if ($urandom_range(0, 63) == 0)
            pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
         pat = {pat[14:0], pat[15]};
         rsp_tready = pat[0];
      end
   end

   // watchdog: cycles without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("adaptive_write_window_rate_controller verification failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin
      dir_row_type  dir_rows[$];
      setting_type  settings[NUM_PHASES];
      int           burst_left;
      int           gap;
      int           kind;
      bit [63:0]    blk;
      clock      = 0;
      reset      = 1;
      req_tvalid = 0;
      req_tdata  = '0;
      req_tuser  = 0;
      rsp_tready = 0;
      csr_valid  = 0;
      csr_index  = REG_BLOCK_BYTES;
      csr_data   = '0;
      errors     = 0;
      hold_req   = 0;
      idle_cycles = 0;
      p_bb = 4096; p_tgt = NS_SEC; p_kib = 0;
      p_mode = MODE_INC; p_win_tgt = 1; p_step = 1; p_lo = 0; p_hi = 0;
      p_win_blk = 0; p_paused = 0; p_hint_ok = 0; p_hint_b = 0; p_hint_spd = 0;
      p_tot_blk = 0; p_tot_time = 0;

      // directed table: empty-window pause, ignored pause blocks, zero time,
      // overfull window, field extremes
      dir_rows = '{
         '{1, 0,         0,          1, 0, 1},
         '{0, 0,         0,          1, 0, 1},
         '{0, 1,         500000000,  1, 1, 2},
         '{0, 1,         0,          1, 0, 2},
         '{1, BLK_FMAX,  1000,       1, 0, 2},
         '{0, 1,         0,          1, 1, 0},
         '{0, BLK_FMAX,  0,          1, 1, 0},
         '{0, 0,         ELA_FMAX,   1, 0, 0},
         '{1, 0,         ELA_FMAX,   0, 0, 0},
         '{0, BLK_FMAX,  ELA_FMAX,   1, 1, 0},
         '{1, 0,         ELA_FMAX,   0, 0, 0},
         '{0, 3,         1000000000, 0, 0, 0},
         '{0, 100,       2000000000, 0, 0, 0},
         '{0, 100,       1,          0, 0, 0},
         '{0, 1000,      999999999,  0, 0, 0},
         '{0, 5000,      1000000001, 0, 0, 0}
      };

      settings[0] = '{512,        1,             0,          0};
      settings[1] = '{16777216,   1000000000000, 4294967295, 0};
      settings[2] = '{65536,      1000000,       100,        1};
      settings[3] = '{0,          1000000000,    5,          0};
      settings[4] = '{1000,       50000000,      1000000,    0};
      settings[5] = '{33554431,   1000000000,    1,          0};
      settings[6] = '{4096,       1000000000,    0,          0};

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      foreach (dir_rows[i])
         send_word(dir_rows[i].is_pause, dir_rows[i].blocks, dir_rows[i].elapsed,
                   dir_rows[i].typed, dir_rows[i].exp_closed, dir_rows[i].exp_bpw);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         drain();
         write_reg(REG_BLOCK_BYTES, settings[ph].bb);
         write_reg(REG_TARGET_NS, settings[ph].tgt);
         write_reg(REG_MAX_RATE, settings[ph].kib);
         if (settings[ph].long_hold) hold_req = 1;
         burst_left = 0;
         for (int n = 0; n < RAND_PER_PHASE; n++) begin
            // bursts with random gaps between them
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 20);
               gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               repeat (gap) @(negedge clock);
            end
            burst_left--;
            kind = $urandom_range(0, 99);
            if (kind < 15) begin
               send_word(1, $urandom & BLK_FMAX, pick_elapsed(1), 0, 0, 0);
            end else begin
               blk = pick_blocks(kind < 70);
               send_word(0, blk, pick_elapsed(0), 0, 0, 0);
            end
         end
      end

      drain();
      if (errors == 0) begin
         $display("adaptive_write_window_rate_controller verification clean");
      end else begin
         $display("adaptive_write_window_rate_controller verification failed");
      end
      $finish;
   end

endmodule
